// ===== rtl/i2p_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg: shared types and constants
// Token kinds, precedence codes, error codes, microcode word layout and the
// microprogram of the infix-to-postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam logic [2:0] KIND_OPERAND = 3'd0;
  localparam logic [2:0] KIND_OPEN    = 3'd1;
  localparam logic [2:0] KIND_CLOSE   = 3'd2;
  localparam logic [2:0] KIND_PLUS    = 3'd3;
  localparam logic [2:0] KIND_MINUS   = 3'd4;
  localparam logic [2:0] KIND_MULDIV  = 3'd5;
  localparam logic [2:0] KIND_POWER   = 3'd6;
  localparam logic [2:0] KIND_FUNC    = 3'd7;

  localparam logic [2:0] PRIO_OPERAND = 3'd0;
  localparam logic [2:0] PRIO_PAREN   = 3'd1;
  localparam logic [2:0] PRIO_ADD     = 3'd3;
  localparam logic [2:0] PRIO_MUL     = 3'd4;
  localparam logic [2:0] PRIO_POW     = 3'd5;
  localparam logic [2:0] PRIO_UNARY   = 3'd6;
  localparam logic [2:0] PRIO_FUNC    = 3'd7;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CLOSE    = 2'd1;
  localparam logic [1:0] ERR_OPEN     = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  typedef enum logic [3:0] {
    ST_FETCH,
    ST_OPND,
    ST_PUSH,
    ST_C_RD,
    ST_C_SCAN,
    ST_C_DROP,
    ST_C_FNRD,
    ST_C_FN,
    ST_C_ERR,
    ST_B_RD,
    ST_B_SCAN,
    ST_TAIL,
    ST_F_RD,
    ST_F_POP,
    ST_FIN
  } i2p_step_e;

  typedef enum logic [2:0] {
    UOP_NONE,
    UOP_EMIT_IN,
    UOP_PUSH,
    UOP_POP,
    UOP_POP_FLUSH,
    UOP_DROP,
    UOP_EMIT_ERR1,
    UOP_FINISH
  } i2p_uop_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_EMPTY,
    COND_TOP_OPEN,
    COND_TOP_LT,
    COND_NOT_FN,
    COND_NOT_LAST
  } i2p_cond_e;

  // When the condition holds the step jumps to t_true and skips its
  // operation; otherwise it performs the operation and goes to t_false.
  typedef struct packed {
    i2p_uop_e  op;
    i2p_cond_e cond;
    i2p_step_e t_true;
    i2p_step_e t_false;
  } i2p_uword_t;

  typedef struct packed {
    logic empty;
    logic top_open;
    logic top_lt;
    logic not_fn;
    logic not_last;
  } i2p_flags_t;

  typedef struct packed {
    i2p_step_e step;
    i2p_uop_e  op;
  } i2p_ctrl_t;

  function automatic i2p_uword_t i2p_rom(i2p_step_e s);
    i2p_uword_t w;
    case (s)
      ST_OPND:   w = '{UOP_EMIT_IN,   COND_NEVER,    ST_TAIL,   ST_TAIL};
      ST_PUSH:   w = '{UOP_PUSH,      COND_NEVER,    ST_TAIL,   ST_TAIL};
      ST_C_RD:   w = '{UOP_NONE,      COND_EMPTY,    ST_C_ERR,  ST_C_SCAN};
      ST_C_SCAN: w = '{UOP_POP,       COND_TOP_OPEN, ST_C_DROP, ST_C_RD};
      ST_C_DROP: w = '{UOP_DROP,      COND_NEVER,    ST_C_FNRD, ST_C_FNRD};
      ST_C_FNRD: w = '{UOP_NONE,      COND_EMPTY,    ST_TAIL,   ST_C_FN};
      ST_C_FN:   w = '{UOP_POP,       COND_NOT_FN,   ST_TAIL,   ST_TAIL};
      ST_C_ERR:  w = '{UOP_EMIT_ERR1, COND_NEVER,    ST_TAIL,   ST_TAIL};
      ST_B_RD:   w = '{UOP_NONE,      COND_EMPTY,    ST_PUSH,   ST_B_SCAN};
      ST_B_SCAN: w = '{UOP_POP,       COND_TOP_LT,   ST_PUSH,   ST_B_RD};
      ST_TAIL:   w = '{UOP_NONE,      COND_NOT_LAST, ST_FIN,    ST_F_RD};
      ST_F_RD:   w = '{UOP_NONE,      COND_EMPTY,    ST_FIN,    ST_F_POP};
      ST_F_POP:  w = '{UOP_POP_FLUSH, COND_NEVER,    ST_F_RD,   ST_F_RD};
      ST_FIN:    w = '{UOP_FINISH,    COND_NEVER,    ST_FETCH,  ST_FETCH};
      default:   w = '{UOP_NONE,      COND_NEVER,    ST_FETCH,  ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/i2p_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_seq: microcode sequencer
// Holds the step counter, reads the control word from the program table and
// picks the next step from the dispatch target or the tested condition.
// ----------------------------------------------------------------------------
module i2p_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  i2p_pkg::i2p_step_e  dispatch_i,
  input  i2p_pkg::i2p_flags_t flags_i,
  input  logic                stall_i,
  output i2p_pkg::i2p_ctrl_t  ctrl_o
);

  i2p_pkg::i2p_step_e  upc_q, upc_d;
  i2p_pkg::i2p_uword_t uword;
  i2p_pkg::i2p_uop_e   op;
  logic                cond_hit;

  assign uword = i2p_pkg::i2p_rom(upc_q);

  always_comb begin
    case (uword.cond)
      i2p_pkg::COND_NEVER:    cond_hit = 1'b0;
      i2p_pkg::COND_EMPTY:    cond_hit = flags_i.empty;
      i2p_pkg::COND_TOP_OPEN: cond_hit = flags_i.top_open;
      i2p_pkg::COND_TOP_LT:   cond_hit = flags_i.top_lt;
      i2p_pkg::COND_NOT_FN:   cond_hit = flags_i.not_fn;
      i2p_pkg::COND_NOT_LAST: cond_hit = flags_i.not_last;
      default:                cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    upc_d = upc_q;
    op    = i2p_pkg::UOP_NONE;
    if (upc_q == i2p_pkg::ST_FETCH) begin
      if (accept_i) begin
        upc_d = dispatch_i;
      end
    end else if (cond_hit) begin
      upc_d = uword.t_true;
    end else begin
      op    = uword.op;
      upc_d = uword.t_false;
    end
    if (stall_i) begin
      upc_d = upc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= i2p_pkg::ST_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o.step = upc_q;
  assign ctrl_o.op   = op;

endmodule

// ===== rtl/infix_to_postfix_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard token reorderer
// Takes classified infix tokens and emits them in postfix order with their
// precedence codes, keeping operators on a bounded stack in block memory.
// ----------------------------------------------------------------------------
// One item is taken at a time. An operand or a plain push passes through
// fetch, operation, end check and result handoff. Every entry popped from the
// operator stack needs a registered read of the stack memory and then the pop.
// A binary operator reads the top of the stack before its push, and compares
// it as well when the stack is not empty. A close parenthesis reads and pops
// entries until it finds the open parenthesis, drops it and reads the entry
// below, then, when the stack is not empty, tests for a function and pops it;
// an unmatched close checks the empty stack and then emits its error marker.
// The final item of an expression then flushes the stack, reading and popping
// each entry until it is empty. Results leave through an output register; the
// sequencer pauses only on a step that must move a result into that register
// while it is full and the sink holds it, and one finished result waits in a
// holding register so that the last result of each item can carry tlast.
// The stack needs no clearing after reset: only entries below the count are
// ever read.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32,
  parameter int TAG_WIDTH   = 8,
  localparam int TdataW     = ((TAG_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TdataW-1:0] s_axis_tdata,  // token_tag
  input  logic [2:0]        s_axis_tuser,  // kind
  input  logic              s_axis_tlast,  // last_token
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TdataW-1:0] m_axis_tdata,  // out_tag
  output logic [6:0]        m_axis_tuser,  // out_priority, is_token,
                                           // expression_end, error_code
  output logic              m_axis_tlast   // last_of_run
);

  localparam int AddrW = $clog2(STACK_DEPTH);
  localparam int CntW  = $clog2(STACK_DEPTH + 1);
  localparam int EntW  = TAG_WIDTH + 3;

  logic [EntW-1:0] mem [STACK_DEPTH];

  logic [CntW-1:0]      count_q, count_d;
  logic [2:0]           prev_kind_q;
  logic                 at_start_q;
  logic                 pend_valid_q;
  logic                 m_valid_q;

  logic [TAG_WIDTH-1:0] tag_q;
  logic                 last_q;
  logic [2:0]           kind_q;
  logic [2:0]           pprio_q;
  logic [EntW-1:0]      rd_q;

  logic [TAG_WIDTH-1:0] pend_tag_q;
  logic [2:0]           pend_prio_q;
  logic                 pend_tok_q;
  logic [1:0]           pend_err_q;

  logic [TAG_WIDTH-1:0] out_tag_q;
  logic [2:0]           out_prio_q;
  logic                 out_tok_q;
  logic                 out_last_q;
  logic                 out_end_q;
  logic [1:0]           out_err_q;

  logic [AddrW-1:0]     rd_addr, wr_addr;
  logic [TAG_WIDTH-1:0] rd_tag;
  logic [2:0]           rd_prio;
  logic                 full;
  logic                 accept;
  logic [2:0]           in_kind;
  logic                 unary;
  logic [2:0]           in_prio;
  i2p_pkg::i2p_step_e   dispatch;
  i2p_pkg::i2p_flags_t  flags;
  i2p_pkg::i2p_ctrl_t   ctrl;
  logic                 op_emits;
  logic                 stall;

  logic                 emit_en;
  logic [TAG_WIDTH-1:0] emit_tag;
  logic [2:0]           emit_prio;
  logic                 emit_tok;
  logic [1:0]           emit_err;
  logic                 push_we;
  logic                 fin;
  logic                 load_pend, load_fin;

  assign rd_addr = AddrW'(count_q - 1'b1);
  assign wr_addr = AddrW'(count_q);
  assign rd_tag  = rd_q[EntW-1:3];
  assign rd_prio = rd_q[2:0];
  assign full    = (count_q == CntW'(STACK_DEPTH));

  assign s_axis_tready = (ctrl.step == i2p_pkg::ST_FETCH);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_kind       = s_axis_tuser;

  always_comb begin
    unary = ((in_kind == i2p_pkg::KIND_PLUS) || (in_kind == i2p_pkg::KIND_MINUS)) &&
            (at_start_q || (prev_kind_q == i2p_pkg::KIND_OPEN) ||
             (prev_kind_q == i2p_pkg::KIND_PLUS) || (prev_kind_q == i2p_pkg::KIND_MINUS) ||
             (prev_kind_q == i2p_pkg::KIND_MULDIV));
    case (in_kind)
      i2p_pkg::KIND_OPERAND: begin
        dispatch = i2p_pkg::ST_OPND;
        in_prio  = i2p_pkg::PRIO_OPERAND;
      end
      i2p_pkg::KIND_OPEN: begin
        dispatch = i2p_pkg::ST_PUSH;
        in_prio  = i2p_pkg::PRIO_PAREN;
      end
      i2p_pkg::KIND_CLOSE: begin
        dispatch = i2p_pkg::ST_C_RD;
        in_prio  = i2p_pkg::PRIO_PAREN;
      end
      i2p_pkg::KIND_PLUS, i2p_pkg::KIND_MINUS: begin
        dispatch = unary ? i2p_pkg::ST_PUSH : i2p_pkg::ST_B_RD;
        in_prio  = unary ? i2p_pkg::PRIO_UNARY : i2p_pkg::PRIO_ADD;
      end
      i2p_pkg::KIND_MULDIV: begin
        dispatch = i2p_pkg::ST_B_RD;
        in_prio  = i2p_pkg::PRIO_MUL;
      end
      i2p_pkg::KIND_POWER: begin
        dispatch = i2p_pkg::ST_PUSH;
        in_prio  = i2p_pkg::PRIO_POW;
      end
      default: begin
        dispatch = i2p_pkg::ST_PUSH;
        in_prio  = i2p_pkg::PRIO_FUNC;
      end
    endcase
  end

  assign flags.empty    = (count_q == '0);
  assign flags.top_open = (rd_prio == i2p_pkg::PRIO_PAREN);
  assign flags.top_lt   = (rd_prio < pprio_q);
  assign flags.not_fn   = (rd_prio != i2p_pkg::PRIO_FUNC);
  assign flags.not_last = !last_q;

  i2p_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .dispatch_i (dispatch),
    .flags_i    (flags),
    .stall_i    (stall),
    .ctrl_o     (ctrl)
  );

  assign op_emits = (ctrl.op == i2p_pkg::UOP_EMIT_IN) || (ctrl.op == i2p_pkg::UOP_POP) ||
                    (ctrl.op == i2p_pkg::UOP_POP_FLUSH) ||
                    (ctrl.op == i2p_pkg::UOP_EMIT_ERR1) ||
                    ((ctrl.op == i2p_pkg::UOP_PUSH) && full);
  assign stall = ((op_emits && pend_valid_q) ||
                  ((ctrl.op == i2p_pkg::UOP_FINISH) && (pend_valid_q || last_q))) &&
                 m_valid_q && !m_axis_tready;

  always_comb begin
    emit_en   = 1'b0;
    emit_tag  = '0;
    emit_prio = i2p_pkg::PRIO_OPERAND;
    emit_tok  = 1'b0;
    emit_err  = i2p_pkg::ERR_NONE;
    push_we   = 1'b0;
    fin       = 1'b0;
    count_d   = count_q;
    if (!stall) begin
      case (ctrl.op)
        i2p_pkg::UOP_EMIT_IN: begin
          emit_en  = 1'b1;
          emit_tag = tag_q;
          emit_tok = 1'b1;
        end
        i2p_pkg::UOP_PUSH: begin
          if (full) begin
            emit_en  = 1'b1;
            emit_err = i2p_pkg::ERR_OVERFLOW;
          end else begin
            push_we = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        i2p_pkg::UOP_POP, i2p_pkg::UOP_POP_FLUSH: begin
          count_d   = count_q - 1'b1;
          emit_en   = 1'b1;
          emit_tag  = rd_tag;
          emit_prio = rd_prio;
          emit_tok  = 1'b1;
          if ((ctrl.op == i2p_pkg::UOP_POP_FLUSH) && (rd_prio == i2p_pkg::PRIO_PAREN)) begin
            emit_err = i2p_pkg::ERR_OPEN;
          end
        end
        i2p_pkg::UOP_DROP: begin
          count_d = count_q - 1'b1;
        end
        i2p_pkg::UOP_EMIT_ERR1: begin
          emit_en  = 1'b1;
          emit_err = i2p_pkg::ERR_CLOSE;
        end
        i2p_pkg::UOP_FINISH: begin
          fin = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign load_pend = emit_en && pend_valid_q;
  assign load_fin  = fin && (pend_valid_q || last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      prev_kind_q  <= i2p_pkg::KIND_OPERAND;
      at_start_q   <= 1'b1;
      pend_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (emit_en) begin
        pend_valid_q <= 1'b1;
      end else if (fin) begin
        pend_valid_q <= 1'b0;
      end
      if (load_pend || load_fin) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (fin) begin
        prev_kind_q <= last_q ? i2p_pkg::KIND_OPERAND : kind_q;
        at_start_q  <= last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_we) begin
      mem[wr_addr] <= {tag_q, pprio_q};
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q   <= s_axis_tdata[TAG_WIDTH-1:0];
      last_q  <= s_axis_tlast;
      kind_q  <= in_kind;
      pprio_q <= in_prio;
    end
    if (emit_en) begin
      pend_tag_q  <= emit_tag;
      pend_prio_q <= emit_prio;
      pend_tok_q  <= emit_tok;
      pend_err_q  <= emit_err;
    end
    if (load_pend) begin
      out_tag_q  <= pend_tag_q;
      out_prio_q <= pend_prio_q;
      out_tok_q  <= pend_tok_q;
      out_err_q  <= pend_err_q;
      out_last_q <= 1'b0;
      out_end_q  <= 1'b0;
    end else if (load_fin) begin
      out_last_q <= 1'b1;
      out_end_q  <= last_q;
      if (pend_valid_q) begin
        out_tag_q  <= pend_tag_q;
        out_prio_q <= pend_prio_q;
        out_tok_q  <= pend_tok_q;
        out_err_q  <= pend_err_q;
      end else begin
        out_tag_q  <= '0;
        out_prio_q <= i2p_pkg::PRIO_OPERAND;
        out_tok_q  <= 1'b0;
        out_err_q  <= i2p_pkg::ERR_NONE;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TdataW'(out_tag_q);
  assign m_axis_tuser  = {out_err_q, out_end_q, out_tok_q, out_prio_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/i2p_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_checker: port-level checks for the infix-to-postfix converter
// Watches the stream ports of the top level and is bound to every instance.
// ----------------------------------------------------------------------------
module i2p_checker #(
  parameter int TAG_WIDTH = 8,
  localparam int TdataW   = ((TAG_WIDTH + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [TdataW-1:0] s_axis_tdata,
  input logic [2:0]        s_axis_tuser,
  input logic              s_axis_tlast,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [TdataW-1:0] m_axis_tdata,
  input logic [6:0]        m_axis_tuser,
  input logic              m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("Output item changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input item accepted while the previous one was in work.");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[4] |-> m_axis_tlast)
    else $error("Expression end on an item that is not the last of its run.");

  a_marker_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[3] |-> (m_axis_tuser[2:0] == 3'd0) &&
      (m_axis_tdata == '0))
    else $error("Bare marker carries a tag or a precedence code.");

  a_token_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |-> !m_axis_tuser[5] &&
      (!m_axis_tuser[6] || (m_axis_tuser[2:0] == 3'd1)))
    else $error("Token item carries an error that only a marker or open paren may carry.");

endmodule

bind infix_to_postfix_converter i2p_checker #(.TAG_WIDTH(TAG_WIDTH)) u_i2p_checker (.*);

// ===== verif/infix_to_postfix_converter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb: self-checking testbench for the converter
// Feeds directed and random infix token streams through the stream ports,
// predicts the postfix items with a software shunting-yard stack, and checks
// every item that leaves the block under varying source and sink stalls.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;

  localparam int STACK_DEPTH  = 32;
  localparam int TAG_WIDTH    = 8;
  localparam int RANDOM_ITEMS = 180;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tag;
    logic       is_last;
  } token_t;

  typedef struct packed {
    logic [7:0] tag;
    logic [2:0] prio;
    logic       is_token;
    logic       run_end;
    logic       expr_end;
    logic [1:0] err;
  } postfix_item_t;

  class postfix_scoreboard;
    postfix_item_t postfix_q[$];
    postfix_item_t run_q[$];
    logic [7:0]    stack_tag[STACK_DEPTH];
    logic [2:0]    stack_prio[STACK_DEPTH];
    int            depth;
    logic [2:0]    prev_kind;
    logic          at_start;
    int            errors;

    function new();
      depth     = 0;
      prev_kind = i2p_pkg::KIND_OPERAND;
      at_start  = 1'b1;
      errors    = 0;
    endfunction

    function void emit_token(logic [7:0] tag, logic [2:0] prio, logic tok, logic [1:0] err);
      postfix_item_t it;
      it = '{tag, prio, tok, 1'b0, 1'b0, err};
      run_q.push_back(it);
    endfunction

    function void pop_operator(logic [1:0] err_if_open);
      logic [2:0] p;
      depth--;
      p = stack_prio[depth];
      emit_token(stack_tag[depth], p, 1'b1,
                 (p == i2p_pkg::PRIO_PAREN) ? err_if_open : i2p_pkg::ERR_NONE);
    endfunction

    function void push_operator(logic [7:0] tag, logic [2:0] prio);
      if (depth < STACK_DEPTH) begin
        stack_tag[depth]  = tag;
        stack_prio[depth] = prio;
        depth++;
      end else begin
        emit_token(8'h00, i2p_pkg::PRIO_OPERAND, 1'b0, i2p_pkg::ERR_OVERFLOW);
      end
    endfunction

    function void convert_token(logic [2:0] kind, logic [7:0] tag, logic is_last);
      logic       unary;
      logic [2:0] p;
      run_q.delete();
      unary = (kind == i2p_pkg::KIND_PLUS || kind == i2p_pkg::KIND_MINUS) &&
              (at_start || prev_kind == i2p_pkg::KIND_OPEN ||
               prev_kind == i2p_pkg::KIND_PLUS || prev_kind == i2p_pkg::KIND_MINUS ||
               prev_kind == i2p_pkg::KIND_MULDIV);
      case (kind)
        i2p_pkg::KIND_OPERAND: emit_token(tag, i2p_pkg::PRIO_OPERAND, 1'b1, i2p_pkg::ERR_NONE);
        i2p_pkg::KIND_OPEN:    push_operator(tag, i2p_pkg::PRIO_PAREN);
        i2p_pkg::KIND_CLOSE: begin
          while (depth != 0 && stack_prio[depth-1] != i2p_pkg::PRIO_PAREN)
            pop_operator(i2p_pkg::ERR_NONE);
          if (depth != 0) begin
            depth--;
            if (depth != 0 && stack_prio[depth-1] == i2p_pkg::PRIO_FUNC)
              pop_operator(i2p_pkg::ERR_NONE);
          end else begin
            emit_token(8'h00, i2p_pkg::PRIO_OPERAND, 1'b0, i2p_pkg::ERR_CLOSE);
          end
        end
        i2p_pkg::KIND_PLUS, i2p_pkg::KIND_MINUS, i2p_pkg::KIND_MULDIV: begin
          if (unary) begin
            push_operator(tag, i2p_pkg::PRIO_UNARY);
          end else begin
            p = (kind == i2p_pkg::KIND_MULDIV) ? i2p_pkg::PRIO_MUL : i2p_pkg::PRIO_ADD;
            while (depth != 0 && stack_prio[depth-1] >= p) pop_operator(i2p_pkg::ERR_NONE);
            push_operator(tag, p);
          end
        end
        i2p_pkg::KIND_POWER: push_operator(tag, i2p_pkg::PRIO_POW);
        default:             push_operator(tag, i2p_pkg::PRIO_FUNC);
      endcase
      if (is_last) begin
        while (depth != 0) pop_operator(i2p_pkg::ERR_OPEN);
        if (run_q.size() == 0)
          emit_token(8'h00, i2p_pkg::PRIO_OPERAND, 1'b0, i2p_pkg::ERR_NONE);
        prev_kind = i2p_pkg::KIND_OPERAND;
        at_start  = 1'b1;
      end else begin
        prev_kind = kind;
        at_start  = 1'b0;
      end
      if (run_q.size() != 0) begin
        run_q[run_q.size()-1].run_end  = 1'b1;
        run_q[run_q.size()-1].expr_end = is_last;
      end
      foreach (run_q[i]) postfix_q.push_back(run_q[i]);
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_postfix_item(logic [7:0] tag, logic [6:0] tuser, logic tlast);
      postfix_item_t got;
      postfix_item_t want;
      got = '{tag, tuser[2:0], tuser[3], tlast, tuser[4], tuser[6:5]};
      if (postfix_q.size() == 0) begin
        report($sformatf("unexpected item tag %h tuser %h tlast %b", tag, tuser, tlast));
      end else begin
        want = postfix_q.pop_front();
        if (got !== want)
          report($sformatf("tag %h/%h prio %0d/%0d tok %b/%b run %b/%b end %b/%b err %0d/%0d",
                           want.tag, got.tag, want.prio, got.prio, want.is_token, got.is_token,
                           want.run_end, got.run_end, want.expr_end, got.expr_end,
                           want.err, got.err));
      end
    endtask
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic [2:0] s_axis_tuser  = '0;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [6:0] m_axis_tuser;
  logic       m_axis_tlast;

  postfix_scoreboard sb;
  token_t            expr_q[$];
  int                src_idle_pct   = 0;
  int                sink_stall_pct = 0;
  logic              hold_go        = 1'b0;
  logic              hold_off       = 1'b0;
  int                items_sent     = 0;
  int                stalled_cycles = 0;
  int                src_pct[4]     = '{0, 55, 0, 9};
  int                sink_pct[4]    = '{0, 0, 55, 9};

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH),
    .TAG_WIDTH  (TAG_WIDTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_postfix_item(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
    m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // The sink holds off for a long stretch so the converter backs up.
  initial begin
    wait (hold_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  function automatic logic [7:0] rand_tag();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_token(logic [2:0] kind, logic [7:0] tag, logic is_last);
    token_t t;
    t = '{kind, tag, is_last};
    expr_q.push_back(t);
  endfunction

  task automatic send_queue();
    foreach (expr_q[i]) begin
      while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= expr_q[i].tag;
      s_axis_tuser  <= expr_q[i].kind;
      s_axis_tlast  <= expr_q[i].is_last;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      sb.convert_token(expr_q[i].kind, expr_q[i].tag, expr_q[i].is_last);
      items_sent++;
    end
    expr_q.delete();
  endtask

  // Mostly well-formed expressions; some random noise, unbalanced
  // parentheses, and deep nesting that may overflow the operator stack.
  task automatic build_expression();
    int         mode;
    int         steps;
    int         depth;
    int         r;
    logic       want_operand;
    logic [2:0] prev;
    expr_q.delete();
    mode = $urandom_range(0, 19);
    if (mode < 2) begin
      repeat ($urandom_range(1, 12))
        add_token(3'($urandom_range(0, 7)), rand_tag(), 1'b0);
    end else if (mode == 4) begin
      depth = $urandom_range(20, 36);
      repeat (depth) add_token(i2p_pkg::KIND_OPEN, rand_tag(), 1'b0);
      add_token(i2p_pkg::KIND_OPERAND, rand_tag(), 1'b0);
      repeat ($urandom_range(depth - 4, depth))
        add_token(i2p_pkg::KIND_CLOSE, rand_tag(), 1'b0);
    end else begin
      depth        = 0;
      want_operand = 1'b1;
      prev         = i2p_pkg::KIND_OPEN;
      steps        = $urandom_range(1, 20);
      for (int i = 0; i < steps || want_operand; i++) begin
        r = $urandom_range(0, 9);
        if (want_operand) begin
          if (i >= steps || r < 4 || (r >= 8 && prev == i2p_pkg::KIND_POWER)) begin
            add_token(i2p_pkg::KIND_OPERAND, rand_tag(), 1'b0);
            want_operand = 1'b0;
            prev         = i2p_pkg::KIND_OPERAND;
          end else if (r < 6) begin
            add_token(i2p_pkg::KIND_OPEN, rand_tag(), 1'b0);
            depth++;
            prev = i2p_pkg::KIND_OPEN;
          end else if (r < 8) begin
            add_token(i2p_pkg::KIND_FUNC, rand_tag(), 1'b0);
            add_token(i2p_pkg::KIND_OPEN, rand_tag(), 1'b0);
            depth++;
            prev = i2p_pkg::KIND_OPEN;
          end else begin
            prev = (r == 8) ? i2p_pkg::KIND_PLUS : i2p_pkg::KIND_MINUS;
            add_token(prev, rand_tag(), 1'b0);
          end
        end else if (depth > 0 && r < 3) begin
          add_token(i2p_pkg::KIND_CLOSE, rand_tag(), 1'b0);
          depth--;
          prev = i2p_pkg::KIND_CLOSE;
        end else begin
          prev = (r < 5) ? i2p_pkg::KIND_PLUS :
                 (r < 7) ? i2p_pkg::KIND_MINUS :
                 (r < 9) ? i2p_pkg::KIND_MULDIV : i2p_pkg::KIND_POWER;
          add_token(prev, rand_tag(), 1'b0);
          want_operand = 1'b1;
        end
      end
      if (mode != 3) repeat (depth) add_token(i2p_pkg::KIND_CLOSE, rand_tag(), 1'b0);
      if (mode == 2) add_token(i2p_pkg::KIND_CLOSE, rand_tag(), 1'b0);
    end
    expr_q[expr_q.size()-1].is_last = 1'b1;
  endtask

  initial begin
    int start_count;
    int phase;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_token(i2p_pkg::KIND_OPERAND, 8'hFF, 1'b1);
    add_token(i2p_pkg::KIND_MINUS,   8'h01, 1'b0);
    add_token(i2p_pkg::KIND_MINUS,   8'h02, 1'b0);
    add_token(i2p_pkg::KIND_OPERAND, 8'h00, 1'b0);
    add_token(i2p_pkg::KIND_POWER,   8'h03, 1'b0);
    add_token(i2p_pkg::KIND_OPERAND, 8'h04, 1'b0);
    add_token(i2p_pkg::KIND_POWER,   8'h05, 1'b0);
    add_token(i2p_pkg::KIND_OPERAND, 8'h06, 1'b0);
    add_token(i2p_pkg::KIND_MULDIV,  8'h07, 1'b0);
    add_token(i2p_pkg::KIND_FUNC,    8'h08, 1'b0);
    add_token(i2p_pkg::KIND_OPEN,    8'h09, 1'b0);
    add_token(i2p_pkg::KIND_OPERAND, 8'h0A, 1'b0);
    add_token(i2p_pkg::KIND_PLUS,    8'h0B, 1'b0);
    add_token(i2p_pkg::KIND_OPERAND, 8'h0C, 1'b0);
    add_token(i2p_pkg::KIND_CLOSE,   8'h0D, 1'b0);
    add_token(i2p_pkg::KIND_MINUS,   8'h0E, 1'b0);
    add_token(i2p_pkg::KIND_OPERAND, 8'h0F, 1'b1);
    add_token(i2p_pkg::KIND_CLOSE,   8'h10, 1'b0);
    add_token(i2p_pkg::KIND_OPEN,    8'h11, 1'b0);
    add_token(i2p_pkg::KIND_CLOSE,   8'h12, 1'b1);
    add_token(i2p_pkg::KIND_MULDIV,  8'h13, 1'b0);
    add_token(i2p_pkg::KIND_OPEN,    8'h14, 1'b0);
    add_token(i2p_pkg::KIND_PLUS,    8'h15, 1'b0);
    add_token(i2p_pkg::KIND_OPERAND, 8'h16, 1'b1);
    add_token(i2p_pkg::KIND_PLUS,    8'h80, 1'b1);
    add_token(i2p_pkg::KIND_OPERAND, 8'h17, 1'b0);
    add_token(i2p_pkg::KIND_PLUS,    8'h18, 1'b0);
    add_token(i2p_pkg::KIND_OPERAND, 8'h19, 1'b0);
    add_token(i2p_pkg::KIND_CLOSE,   8'h1A, 1'b1);
    repeat (STACK_DEPTH + 2) add_token(i2p_pkg::KIND_OPEN, rand_tag(), 1'b0);
    add_token(i2p_pkg::KIND_OPERAND, 8'hA5, 1'b0);
    add_token(i2p_pkg::KIND_CLOSE,   8'h5A, 1'b1);
    send_queue();

    hold_go     <= 1'b1;
    start_count  = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      phase          = (items_sent - start_count) * 4 / RANDOM_ITEMS;
      src_idle_pct   = src_pct[phase];
      sink_stall_pct = sink_pct[phase];
      build_expression();
      send_queue();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.postfix_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.postfix_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
